### hw/rtl/sactl_pkg.sv
// shared types and sizing constants for the set-associative tag store with lru
// no dependencies
`default_nettype none

package sactl_pkg;

	localparam int WAYS        = 8;
	localparam int OFFSET_BITS = 6;
	localparam int INDEX_BITS  = 6;
	localparam int ADDR_BITS   = 48;
	localparam int AGE_BITS    = 16;

	localparam int TAG_BITS = ADDR_BITS - OFFSET_BITS - INDEX_BITS;
	localparam int WAY_BITS = $clog2(WAYS);
	localparam int NUM_SETS = 1 << INDEX_BITS;

	localparam logic [AGE_BITS-1:0] AGE_MAX = {AGE_BITS{1'b1}};

	typedef struct packed {
		logic                vld;
		logic [TAG_BITS-1:0] tag;
		logic [AGE_BITS-1:0] age;
	} way_ent_t;

	typedef way_ent_t [WAYS-1:0] set_row_t;

	typedef struct packed {
		logic                hit;
		logic [WAY_BITS-1:0] way;
		logic                evicted;
	} lookup_res_t;

endpackage

`default_nettype wire

### hw/rtl/sactl_lookup.sv
// tag compare, victim choice and age update for one set row
// depends on sactl_pkg
`default_nettype none

module sactl_lookup (
	input  sactl_pkg::set_row_t             row_in,
	input  logic [sactl_pkg::TAG_BITS-1:0]  tag,
	output sactl_pkg::lookup_res_t          res,
	output sactl_pkg::set_row_t             row_out
);
	import sactl_pkg::*;

	logic                hit;
	logic [WAY_BITS-1:0] hit_way;
	logic                free_found;
	logic [WAY_BITS-1:0] free_way;
	logic [WAY_BITS-1:0] old_way;
	logic [AGE_BITS-1:0] best_age;
	logic [WAY_BITS-1:0] way_sel;

	// lowest matching way and lowest invalid way
	always_comb begin
		hit        = 1'b0;
		hit_way    = '0;
		free_found = 1'b0;
		free_way   = '0;
		for (int i = WAYS - 1; i >= 0; i--) begin
			if (row_in[i].vld && row_in[i].tag == tag) begin
				hit     = 1'b1;
				hit_way = WAY_BITS'(i);
			end
			if (!row_in[i].vld) begin
				free_found = 1'b1;
				free_way   = WAY_BITS'(i);
			end
		end
	end

	// oldest way, strict compare keeps the lower way on a tie
	always_comb begin
		best_age = row_in[0].age;
		old_way  = '0;
		for (int i = 1; i < WAYS; i++) begin
			if (row_in[i].age > best_age) begin
				best_age = row_in[i].age;
				old_way  = WAY_BITS'(i);
			end
		end
	end

	always_comb begin
		if (hit) begin
			way_sel = hit_way;
		end else if (free_found) begin
			way_sel = free_way;
		end else begin
			way_sel = old_way;
		end
		res.hit     = hit;
		res.way     = way_sel;
		res.evicted = !hit && !free_found;
	end

	always_comb begin
		for (int i = 0; i < WAYS; i++) begin
			row_out[i] = row_in[i];
			if (row_in[i].age != AGE_MAX) begin
				row_out[i].age = row_in[i].age + 1'b1;
			end
			if (way_sel == WAY_BITS'(i)) begin
				row_out[i].age = '0;
				if (!hit) begin
					row_out[i].vld = 1'b1;
					row_out[i].tag = tag;
				end
			end
		end
	end

endmodule

`default_nettype wire

### hw/rtl/set_assoc_cache_tag_lru.sv
// result: the outputs are registered from the lookup and shown with rsp_valid
// stall: req_stall holds off a new address while a set row is in its read-modify-write
// in the set memory (read at accept, write back on the next edge) or a response is stalled
// reset: control clears at once; a per-set flag makes every set read as empty
// (all ways invalid, ages zero) until its first write, so no clearing pass runs
// depends on sactl_pkg and sactl_lookup
`default_nettype none

module set_assoc_cache_tag_lru (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               req_valid,
	output logic                               req_stall,
	input  logic [sactl_pkg::ADDR_BITS-1:0]    address,
	output logic                               rsp_valid,
	input  logic                               rsp_stall,
	output logic                               hit,
	output logic [sactl_pkg::WAY_BITS-1:0]     way_used,
	output logic [sactl_pkg::INDEX_BITS-1:0]   set_index,
	output logic [sactl_pkg::TAG_BITS-1:0]     line_tag,
	output logic                               evicted
);
	import sactl_pkg::*;

	set_row_t             set_mem [NUM_SETS];
	logic [NUM_SETS-1:0]  set_init_q;

	logic                  busy_s1;
	logic [INDEX_BITS-1:0] idx_s1;
	logic [TAG_BITS-1:0]   tag_s1;
	set_row_t              rd_row_s1;
	logic                  row_ok_s1;

	logic                  rsp_valid_q;
	logic                  accept;
	logic [INDEX_BITS-1:0] req_idx;
	set_row_t              row_cur;
	set_row_t              row_new;
	lookup_res_t           lk_res;

	assign req_idx   = address[OFFSET_BITS+INDEX_BITS-1:OFFSET_BITS];
	assign req_stall = busy_s1 || (rsp_valid_q && rsp_stall);
	assign accept    = req_valid && !req_stall;
	assign rsp_valid = rsp_valid_q;

	// sets not yet written since reset read as empty
	assign row_cur = row_ok_s1 ? rd_row_s1 : '0;

	sactl_lookup u_lookup (
		.row_in  (row_cur),
		.tag     (tag_s1),
		.res     (lk_res),
		.row_out (row_new)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			rd_row_s1 <= set_mem[req_idx];
		end
		if (busy_s1) begin
			set_mem[idx_s1] <= row_new;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			idx_s1 <= req_idx;
			tag_s1 <= address[ADDR_BITS-1:OFFSET_BITS+INDEX_BITS];
		end
		if (busy_s1) begin
			hit       <= lk_res.hit;
			way_used  <= lk_res.way;
			evicted   <= lk_res.evicted;
			set_index <= idx_s1;
			line_tag  <= tag_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s1     <= 1'b0;
			row_ok_s1   <= 1'b0;
			rsp_valid_q <= 1'b0;
			set_init_q  <= '0;
		end else begin
			busy_s1 <= accept;
			if (accept) begin
				row_ok_s1 <= set_init_q[req_idx];
			end
			if (busy_s1) begin
				set_init_q[idx_s1] <= 1'b1;
				rsp_valid_q        <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire
